@@ hdl/dpgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpgs_pkg
// Shared types, register codes and threshold helper for the double pulse
// gate sequencer.
// ----------------------------------------------------------------------------
package dpgs_pkg;

    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CHARGE_W   = 24;
    localparam int DEAD_W     = 16;
    localparam int GAP_W      = 24;
    localparam int LOCK_W     = 32;
    // C + G + 3D stays below 2^26
    localparam int TH_W       = 26;

    localparam logic [CHARGE_W-1:0] CHARGE_RESET  = CHARGE_W'(2812);
    localparam logic [DEAD_W-1:0]   DEAD_RESET    = DEAD_W'(14);
    localparam logic [GAP_W-1:0]    GAP_RESET     = GAP_W'(749);
    localparam logic [LOCK_W-1:0]   LOCKOUT_RESET = LOCK_W'(750000000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CHARGE  = 2'd0,
        CFG_DEAD    = 2'd1,
        CFG_GAP     = 2'd2,
        CFG_LOCKOUT = 2'd3
    } cfg_addr_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEQ  = 2'd1,
        MODE_LOCK = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CHARGE  = 3'd1,
        PH_DEAD1   = 3'd2,
        PH_GAP     = 3'd3,
        PH_DEAD2   = 3'd4,
        PH_PULSE2  = 3'd5,
        PH_TAIL    = 3'd6,
        PH_LOCKOUT = 3'd7
    } phase_t;

    // last elapsed tick of each region, plus the lockout length
    typedef struct packed {
        logic [TH_W-1:0]   charge_end;
        logic [TH_W-1:0]   dead1_end;
        logic [TH_W-1:0]   gap_end;
        logic [TH_W-1:0]   dead2_end;
        logic [TH_W-1:0]   pulse2_end;
        logic [TH_W-1:0]   tail_end;
        logic [LOCK_W-1:0] lockout;
    } thresh_t;

    function automatic thresh_t calc_thresh(
        input logic [CHARGE_W-1:0] charge,
        input logic [DEAD_W-1:0]   dead,
        input logic [GAP_W-1:0]    gap,
        input logic [LOCK_W-1:0]   lockout
    );
        thresh_t         th;
        logic [TH_W-1:0] cg;
        logic [TH_W-1:0] d_ext;
        d_ext         = TH_W'(dead);
        cg            = TH_W'(charge) + TH_W'(gap);
        th.charge_end = TH_W'(charge);
        th.dead1_end  = TH_W'(charge) + d_ext;
        th.gap_end    = cg;
        th.dead2_end  = cg + d_ext;
        th.pulse2_end = cg + (d_ext << 1);
        th.tail_end   = cg + d_ext + (d_ext << 1);
        th.lockout    = lockout;
        return th;
    endfunction

endpackage

@@ hdl/dpgs_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpgs_cfg
// Timing registers and registered region thresholds derived from them.
// ----------------------------------------------------------------------------
module dpgs_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [dpgs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dpgs_pkg::CFG_W-1:0]       cfg_wdata,
    output dpgs_pkg::thresh_t                thresh
);

    logic [dpgs_pkg::CHARGE_W-1:0] charge_reg;
    logic [dpgs_pkg::DEAD_W-1:0]   dead_reg;
    logic [dpgs_pkg::GAP_W-1:0]    gap_reg;
    logic [dpgs_pkg::LOCK_W-1:0]   lockout_reg;
    logic [dpgs_pkg::CHARGE_W-1:0] charge_next;
    logic [dpgs_pkg::DEAD_W-1:0]   dead_next;
    logic [dpgs_pkg::GAP_W-1:0]    gap_next;
    logic [dpgs_pkg::LOCK_W-1:0]   lockout_next;
    dpgs_pkg::thresh_t             thresh_reg;
    dpgs_pkg::thresh_t             thresh_next;

    always_comb begin
        charge_next  = charge_reg;
        dead_next    = dead_reg;
        gap_next     = gap_reg;
        lockout_next = lockout_reg;
        if (cfg_we) begin
            unique case (dpgs_pkg::cfg_addr_t'(cfg_addr))
                dpgs_pkg::CFG_CHARGE:  charge_next  = cfg_wdata[dpgs_pkg::CHARGE_W-1:0];
                dpgs_pkg::CFG_DEAD:    dead_next    = cfg_wdata[dpgs_pkg::DEAD_W-1:0];
                dpgs_pkg::CFG_GAP:     gap_next     = cfg_wdata[dpgs_pkg::GAP_W-1:0];
                dpgs_pkg::CFG_LOCKOUT: lockout_next = cfg_wdata[dpgs_pkg::LOCK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_reg  <= dpgs_pkg::CHARGE_RESET;
            dead_reg    <= dpgs_pkg::DEAD_RESET;
            gap_reg     <= dpgs_pkg::GAP_RESET;
            lockout_reg <= dpgs_pkg::LOCKOUT_RESET;
        end else begin
            charge_reg  <= charge_next;
            dead_reg    <= dead_next;
            gap_reg     <= gap_next;
            lockout_reg <= lockout_next;
        end
    end

    assign thresh_next = dpgs_pkg::calc_thresh(charge_next, dead_next, gap_next, lockout_next);

    // region ends load on the same edge as the register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= dpgs_pkg::calc_thresh(dpgs_pkg::CHARGE_RESET, dpgs_pkg::DEAD_RESET,
                                                dpgs_pkg::GAP_RESET, dpgs_pkg::LOCKOUT_RESET);
        end else begin
            thresh_reg <= thresh_next;
        end
    end

    assign thresh = thresh_reg;

endmodule

@@ hdl/dpgs_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpgs_core
// Input register, sequence state, phase decode and output register.
// ----------------------------------------------------------------------------
module dpgs_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dpgs_pkg::thresh_t thresh,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_trigger,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_gate_a,
    output logic              m_gate_b,
    output logic [2:0]        m_phase_code
);

    localparam int CMP_W = (COUNT_WIDTH > dpgs_pkg::LOCK_W) ? COUNT_WIDTH : dpgs_pkg::LOCK_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    logic                   in_vld_reg;
    logic                   trig_reg;
    logic                   out_vld_reg;
    logic                   ga_reg;
    logic                   gb_reg;
    dpgs_pkg::phase_t       ph_reg;
    dpgs_pkg::mode_t        mode_reg;
    dpgs_pkg::mode_t        mode_next;
    logic [COUNT_WIDTH-1:0] t_reg;
    logic [COUNT_WIDTH-1:0] t_next;
    dpgs_pkg::phase_t       ph_next;

    logic                   out_free;
    logic                   step;
    logic                   seq_start;
    logic                   in_seq;
    logic                   seq_done;
    logic                   in_lock;
    logic                   lock_done;
    logic [COUNT_WIDTH-1:0] t_seq;
    logic [COUNT_WIDTH-1:0] t_lock;
    logic [COUNT_WIDTH-1:0] t_seq_inc;
    logic [COUNT_WIDTH-1:0] t_lock_inc;
    logic [CMP_W-1:0]       t_seq_x;
    dpgs_pkg::phase_t       seq_phase;

    // handshake: output register frees up whenever its transaction is taken
    assign out_free = !out_vld_reg || m_ready;
    assign step     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    // decode of the current tick
    assign seq_start  = (mode_reg == dpgs_pkg::MODE_IDLE) && trig_reg;
    assign in_seq     = (mode_reg == dpgs_pkg::MODE_SEQ) || seq_start;
    assign t_seq      = seq_start ? '0 : t_reg;
    assign t_seq_x    = CMP_W'(t_seq);
    assign seq_done   = t_seq_x > CMP_W'(thresh.tail_end);
    assign in_lock    = (mode_reg == dpgs_pkg::MODE_LOCK) || (in_seq && seq_done);
    // sequence end drops straight into lockout with the count at zero
    assign t_lock     = (mode_reg == dpgs_pkg::MODE_LOCK) ? t_reg : '0;
    assign lock_done  = CMP_W'(t_lock) >= CMP_W'(thresh.lockout);
    assign t_seq_inc  = (&t_seq) ? t_seq : t_seq + COUNT_ONE;
    assign t_lock_inc = (&t_lock) ? t_lock : t_lock + COUNT_ONE;

    always_comb begin
        if (t_seq_x <= CMP_W'(thresh.charge_end)) begin
            seq_phase = dpgs_pkg::PH_CHARGE;
        end else if (t_seq_x <= CMP_W'(thresh.dead1_end)) begin
            seq_phase = dpgs_pkg::PH_DEAD1;
        end else if (t_seq_x <= CMP_W'(thresh.gap_end)) begin
            seq_phase = dpgs_pkg::PH_GAP;
        end else if (t_seq_x <= CMP_W'(thresh.dead2_end)) begin
            seq_phase = dpgs_pkg::PH_DEAD2;
        end else if (t_seq_x <= CMP_W'(thresh.pulse2_end)) begin
            seq_phase = dpgs_pkg::PH_PULSE2;
        end else begin
            seq_phase = dpgs_pkg::PH_TAIL;
        end
    end

    // next state
    always_comb begin
        mode_next = mode_reg;
        t_next    = t_reg;
        if (in_seq && !seq_done) begin
            mode_next = dpgs_pkg::MODE_SEQ;
            t_next    = t_seq_inc;
        end else if (in_lock) begin
            if (lock_done) begin
                // a trigger on the last lockout tick restarts at once
                if (trig_reg) begin
                    mode_next = dpgs_pkg::MODE_SEQ;
                    t_next    = COUNT_ONE;
                end else begin
                    mode_next = dpgs_pkg::MODE_IDLE;
                    t_next    = '0;
                end
            end else begin
                mode_next = dpgs_pkg::MODE_LOCK;
                t_next    = t_lock_inc;
            end
        end
    end

    // outputs of this tick
    always_comb begin
        if (in_seq && !seq_done) begin
            ph_next = seq_phase;
        end else if (in_lock) begin
            if (lock_done) begin
                ph_next = trig_reg ? dpgs_pkg::PH_CHARGE : dpgs_pkg::PH_IDLE;
            end else begin
                ph_next = dpgs_pkg::PH_LOCKOUT;
            end
        end else begin
            ph_next = dpgs_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mode_reg    <= dpgs_pkg::MODE_IDLE;
            t_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end
            if (step) begin
                mode_reg <= mode_next;
                t_reg    <= t_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            trig_reg <= s_trigger;
        end
        if (step) begin
            ph_reg <= ph_next;
            ga_reg <= (ph_next == dpgs_pkg::PH_CHARGE) || (ph_next == dpgs_pkg::PH_PULSE2);
            gb_reg <= (ph_next == dpgs_pkg::PH_GAP);
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_gate_a     = ga_reg;
    assign m_gate_b     = gb_reg;
    assign m_phase_code = ph_reg;

endmodule

@@ hdl/double_pulse_gate_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_pulse_gate_sequencer
// Double pulse test gate generator: gate A charge pulse, gate B gap pulse,
// gate A second pulse, with dead times, a tail and a lockout.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ transaction is one timing tick carrying s_trigger, a qualified
//   falling edge. Each tick yields exactly one m_ transaction with the gate
//   drives and the phase code (0 idle .. 7 lockout).
//   Timing registers are written through cfg_we / cfg_addr / cfg_wdata while
//   no transaction is in flight; index 0 charge, 1 dead, 2 gap, 3 lockout.
//   A transaction taken from s_ sits in the input register, and the output
//   register loads its result and raises m_valid once that register is free.
//   The phase compares against registered region ends sit between those two
//   registers. Throughput is one transaction per cycle while m_ready is high,
//   set by that single compare stage.
//   When m_ready is low the result holds in the output register and one more
//   transaction is still taken into the input register; s_ready then drops.
//   Reset (synchronous, active low) returns to idle with the count at zero
//   and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
module double_pulse_gate_sequencer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_trigger,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_gate_a,
    output logic                            m_gate_b,
    output logic [2:0]                      m_phase_code,
    input  logic                            cfg_we,
    input  logic [dpgs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dpgs_pkg::CFG_W-1:0]      cfg_wdata
);

    dpgs_pkg::thresh_t thresh;

    dpgs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .thresh    (thresh)
    );

    dpgs_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .thresh       (thresh),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_trigger    (s_trigger),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gate_a     (m_gate_a),
        .m_gate_b     (m_gate_b),
        .m_phase_code (m_phase_code)
    );

endmodule

@@ hdl/dpgs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpgs_checker
// Port level checks for the double pulse gate sequencer.
// ----------------------------------------------------------------------------
module dpgs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_gate_a,
    input logic       m_gate_b,
    input logic [2:0] m_phase_code
);

    // both switches on at once would short the leg
    a_no_shoot_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_gate_a && m_gate_b))
        else $error("gate a and gate b both on");

    a_gate_a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gate_a == ((m_phase_code == dpgs_pkg::PH_CHARGE) ||
                                  (m_phase_code == dpgs_pkg::PH_PULSE2))))
        else $error("gate a does not match phase");

    a_gate_b_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gate_b == (m_phase_code == dpgs_pkg::PH_GAP)))
        else $error("gate b does not match phase");

    // input side only backs up behind a stalled result
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_gate_a) && $stable(m_gate_b)
                                   && $stable(m_phase_code)))
        else $error("stalled result changed");

endmodule

bind double_pulse_gate_sequencer dpgs_checker u_dpgs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_gate_a     (m_gate_a),
    .m_gate_b     (m_gate_b),
    .m_phase_code (m_phase_code)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double pulse gate sequencer. Tick transactions
// carry random and hand-picked trigger patterns under many timing settings.
// The settings include all-zero and all-ones registers and registers rewritten
// in the middle of a sequence. A tick-by-tick gate timeline model predicts
// every result transaction. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COUNT_W     = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic             gate_a;
        logic             gate_b;
        dpgs_pkg::phase_t phase;
    } gate_word_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_trigger = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_gate_a;
    logic                           m_gate_b;
    logic [2:0]                     m_phase_code;
    logic                           cfg_we = 1'b0;
    dpgs_pkg::cfg_addr_t            cfg_addr = dpgs_pkg::CFG_CHARGE;
    logic [dpgs_pkg::CFG_W-1:0]     cfg_wdata = '0;

    // gate timeline model state
    logic [dpgs_pkg::CHARGE_W-1:0]  charge_len;
    logic [dpgs_pkg::DEAD_W-1:0]    dead_len;
    logic [dpgs_pkg::GAP_W-1:0]     gap_len;
    logic [dpgs_pkg::LOCK_W-1:0]    lock_len;
    dpgs_pkg::mode_t                seq_state;
    logic [COUNT_W-1:0]             tick_count;

    bit                    pending_ticks[$];
    gate_word_t            gate_expect_q[$];
    logic                  tick_taken = 1'b0;
    bit                    send_idle = 1'b0;
    bit                    recv_idle = 1'b0;
    int                    send_wait = 0;
    int                    recv_wait = 0;
    int                    cycle_count = 0;
    int                    mismatch_count = 0;
    int                    results_seen = 0;
    int                    triggers_sent = 0;
    int                    lockout_ticks_seen = 0;
    int                    cfg_writes = 0;
    int                    settings_used = 0;

    double_pulse_gate_sequencer #(
        .COUNT_WIDTH(COUNT_W)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_trigger   (s_trigger),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_gate_a    (m_gate_a),
        .m_gate_b    (m_gate_b),
        .m_phase_code(m_phase_code),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void bump_tick();
        if (tick_count != '1) begin
            tick_count = tick_count + 1'b1;
        end
    endfunction

    function automatic gate_word_t predict_gate_tick(input logic trig);
        gate_word_t  w;
        logic [63:0] t;
        logic [63:0] cg;
        logic [63:0] d;
        w.gate_a = 1'b0;
        w.gate_b = 1'b0;
        w.phase  = dpgs_pkg::PH_IDLE;
        cg = 64'(charge_len) + 64'(gap_len);
        d  = 64'(dead_len);
        if (seq_state == dpgs_pkg::MODE_IDLE && trig) begin
            seq_state  = dpgs_pkg::MODE_SEQ;
            tick_count = '0;
        end
        if (seq_state == dpgs_pkg::MODE_SEQ) begin
            t = 64'(tick_count);
            if (t > cg + 3 * d) begin
                seq_state  = dpgs_pkg::MODE_LOCK;
                tick_count = '0;
            end else begin
                if (t <= 64'(charge_len)) begin
                    w.gate_a = 1'b1;
                    w.phase  = dpgs_pkg::PH_CHARGE;
                end else if (t <= 64'(charge_len) + d) begin
                    w.phase = dpgs_pkg::PH_DEAD1;
                end else if (t <= cg) begin
                    w.gate_b = 1'b1;
                    w.phase  = dpgs_pkg::PH_GAP;
                end else if (t <= cg + d) begin
                    w.phase = dpgs_pkg::PH_DEAD2;
                end else if (t <= cg + 2 * d) begin
                    w.gate_a = 1'b1;
                    w.phase  = dpgs_pkg::PH_PULSE2;
                end else begin
                    w.phase = dpgs_pkg::PH_TAIL;
                end
                bump_tick();
            end
        end
        if (seq_state == dpgs_pkg::MODE_LOCK) begin
            if (tick_count >= lock_len) begin
                seq_state  = dpgs_pkg::MODE_IDLE;
                tick_count = '0;
                // lockout end: a trigger here starts the next sequence at once
                if (trig) begin
                    seq_state = dpgs_pkg::MODE_SEQ;
                    w.gate_a  = 1'b1;
                    w.phase   = dpgs_pkg::PH_CHARGE;
                    bump_tick();
                end
            end else begin
                w.phase = dpgs_pkg::PH_LOCKOUT;
                bump_tick();
            end
        end
        return w;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_wait();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] %s mismatch at result %0d: got %0d, expected %0d",
                     $time, field, results_seen, got, want);
        end
    endtask

    // driver: one tick transaction at a time, gaps between them when send_idle is set
    always @(negedge aclk) begin
        if (s_valid && !tick_taken) begin
            // hold until the transaction is taken
        end else if (send_wait > 0) begin
            s_valid <= 1'b0;
            send_wait = send_wait - 1;
        end else if (pending_ticks.size() > 0) begin
            s_valid   <= 1'b1;
            s_trigger <= pending_ticks.pop_front();
            send_wait = send_idle ? pick_wait() : 0;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (recv_wait > 0) begin
            m_ready <= 1'b0;
            recv_wait = recv_wait - 1;
        end else begin
            m_ready <= 1'b1;
            recv_wait = recv_idle ? pick_wait() : 0;
        end
    end

    // monitor and predictor
    always @(posedge aclk) begin
        gate_word_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, gate_expect_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            tick_taken <= s_valid && s_ready && aresetn;
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    if (gate_expect_q.size() == 0) begin
                        report_mismatch("unexpected transaction", m_phase_code, -1);
                    end else begin
                        want = gate_expect_q.pop_front();
                        if (m_gate_a !== want.gate_a) begin
                            report_mismatch("gate_a", m_gate_a, want.gate_a);
                        end
                        if (m_gate_b !== want.gate_b) begin
                            report_mismatch("gate_b", m_gate_b, want.gate_b);
                        end
                        if (m_phase_code !== want.phase) begin
                            report_mismatch("phase_code", m_phase_code, want.phase);
                        end
                        if (want.phase == dpgs_pkg::PH_LOCKOUT) begin
                            lockout_ticks_seen++;
                        end
                    end
                    results_seen++;
                end
                if (s_valid && s_ready) begin
                    gate_expect_q.push_back(predict_gate_tick(s_trigger));
                    if (s_trigger) begin
                        triggers_sent++;
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_ticks.size() > 0 || s_valid || gate_expect_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_timing(dpgs_pkg::cfg_addr_t idx, logic [dpgs_pkg::CFG_W-1:0] data);
        wait_drained();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            dpgs_pkg::CFG_CHARGE:  charge_len = data[dpgs_pkg::CHARGE_W-1:0];
            dpgs_pkg::CFG_DEAD:    dead_len   = data[dpgs_pkg::DEAD_W-1:0];
            dpgs_pkg::CFG_GAP:     gap_len    = data[dpgs_pkg::GAP_W-1:0];
            dpgs_pkg::CFG_LOCKOUT: lock_len   = data[dpgs_pkg::LOCK_W-1:0];
        endcase
        cfg_writes++;
        // region ends are registered inside the block
        repeat (2) @(negedge aclk);
    endtask

    task automatic send_pattern(string bits);
        for (int i = 0; i < bits.len(); i++) begin
            pending_ticks.push_back(bits[i] == "1");
        end
        wait_drained();
    endtask

    task automatic send_random(int count, int trig_pct);
        for (int i = 0; i < count; i++) begin
            pending_ticks.push_back($urandom_range(0, 99) < trig_pct);
        end
        wait_drained();
    endtask

    initial begin
        int pct;
        charge_len = dpgs_pkg::CHARGE_RESET;
        dead_len   = dpgs_pkg::DEAD_RESET;
        gap_len    = dpgs_pkg::GAP_RESET;
        lock_len   = dpgs_pkg::LOCKOUT_RESET;
        seq_state  = dpgs_pkg::MODE_IDLE;
        tick_count = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset timing: a trigger starts charge on its own tick
        settings_used++;
        send_pattern("00101");
        // all zero, rewritten mid-charge; upper garbage bits must be dropped
        settings_used++;
        load_timing(dpgs_pkg::CFG_CHARGE, 32'hFF00_0000);
        load_timing(dpgs_pkg::CFG_DEAD, 32'hABCD_0000);
        load_timing(dpgs_pkg::CFG_GAP, 32'h5A00_0000);
        load_timing(dpgs_pkg::CFG_LOCKOUT, 32'h0000_0000);
        send_pattern("11011001");
        // gap region empty, trigger lands on lockout end
        settings_used++;
        load_timing(dpgs_pkg::CFG_CHARGE, 32'd1);
        load_timing(dpgs_pkg::CFG_DEAD, 32'd2);
        load_timing(dpgs_pkg::CFG_GAP, 32'd1);
        load_timing(dpgs_pkg::CFG_LOCKOUT, 32'd3);
        send_pattern("1010010001011");

        for (int p = 0; p < 12; p++) begin
            settings_used++;
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            load_timing(dpgs_pkg::CFG_CHARGE, {8'($urandom), 24'($urandom_range(0, 10))});
            load_timing(dpgs_pkg::CFG_DEAD, {16'($urandom), 16'($urandom_range(0, 3))});
            load_timing(dpgs_pkg::CFG_GAP, {8'($urandom), 24'($urandom_range(0, 10))});
            load_timing(dpgs_pkg::CFG_LOCKOUT, 32'($urandom_range(0, 12)));
            case ($urandom_range(0, 3))
                0: pct = 3;
                1: pct = 20;
                2: pct = 60;
                default: pct = 95;
            endcase
            send_random(55, pct);
        end

        // all ones, then walk the sequence forward by shrinking registers mid-run
        settings_used++;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        load_timing(dpgs_pkg::CFG_CHARGE, 32'hFFFF_FFFF);
        load_timing(dpgs_pkg::CFG_DEAD, 32'hFFFF_FFFF);
        load_timing(dpgs_pkg::CFG_GAP, 32'hFFFF_FFFF);
        load_timing(dpgs_pkg::CFG_LOCKOUT, 32'hFFFF_FFFF);
        send_random(20, 40);
        load_timing(dpgs_pkg::CFG_CHARGE, 32'd0);
        send_random(10, 40);
        load_timing(dpgs_pkg::CFG_DEAD, 32'd0);
        send_random(10, 40);
        load_timing(dpgs_pkg::CFG_GAP, 32'd0);
        send_random(10, 40);
        load_timing(dpgs_pkg::CFG_LOCKOUT, 32'd5);
        send_random(15, 40);

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("checked %0d tick results with %0d triggers, %0d of them in lockout",
                 results_seen, triggers_sent, lockout_ticks_seen);
        $display("%0d register writes over %0d timing settings, %0d mismatches",
                 cfg_writes, settings_used, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
